>>> hw/rtl/sphere_polyline_contact_classifier_macros.svh
// Assertion macros for the sphere / polyline contact classifier.
`ifndef SPHERE_POLYLINE_CONTACT_CLASSIFIER_MACROS_SVH
`define SPHERE_POLYLINE_CONTACT_CLASSIFIER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define SPC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spc assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define SPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spc assertion failed");

`endif

>>> hw/rtl/spc_pkg.sv
// Shared types, widths and the microprogram of the contact classifier.
`default_nettype none

package spc_pkg;

    // Coordinates are Q15.8; the scale never enters a decision.
    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MUL_W     = COORD_W + 2;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int PIECE_W   = COORD_W + 1;
    localparam int MAG_W     = 2 * PIECE_W;
    localparam int DD_W      = MAG_W;
    localparam int NUM_W     = 2 * MAG_W;
    localparam int ACC_W     = NUM_W + 2;
    localparam int RADIUS_W  = 20;
    localparam int MARGIN_W  = 16;
    localparam int T_W       = RADIUS_W + 1;
    localparam int TSQ_W     = 2 * T_W;
    localparam int CFG_W     = COORD_W;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W      = 7;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1280);
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(102);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_RADIUS   = 3'd3,
        CFG_MARGIN   = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STAT_INTERSECT = 2'd0,
        STAT_TOUCH     = 2'd1,
        STAT_AWAY      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_RUN,
        CTL_COMMIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MUL,
        OP_STORE,
        OP_BRANCH,
        OP_JUMP,
        OP_DONE
    } uop_kind_t;

    // Multiplier operand sources.
    typedef enum logic [4:0] {
        SRC_D0, SRC_D1, SRC_D2,
        SRC_W0, SRC_W1, SRC_W2,
        SRC_V0, SRC_V1, SRC_V2,
        SRC_CH0, SRC_CH1, SRC_CH2,
        SRC_CL0, SRC_CL1, SRC_CL2,
        SRC_TIN, SRC_TOUT,
        SRC_DENH, SRC_DENL,
        SRC_TSQH, SRC_TSQL
    } src_t;

    // Left shift of a product before it enters the accumulator.
    typedef enum logic [2:0] {
        SH_0,   // none
        SH_T,   // T_W
        SH_P,   // PIECE_W
        SH_P1,  // PIECE_W + 1 (doubled cross term)
        SH_PT,  // PIECE_W + T_W
        SH_PP   // 2 * PIECE_W
    } shift_t;

    typedef enum logic [3:0] {
        DST_DD,
        DST_WD,
        DST_CR0,
        DST_CR1,
        DST_CR2,
        DST_NUM_DD,
        DST_NUM_ONE,
        DST_TSQ,
        DST_CMP_IN,
        DST_CMP_TOUCH
    } dst_t;

    typedef struct packed {
        uop_kind_t       kind;
        src_t            a;
        src_t            b;
        shift_t          shift;
        logic            neg;
        logic            clr;
        dst_t            dst;
        logic [PC_W-1:0] target;
    } uop_t;

    typedef struct packed {
        logic   load;
        logic   mul_en;
        src_t   a;
        src_t   b;
        shift_t shift;
        logic   neg;
        logic   clr;
        logic   st_en;
        dst_t   dst;
        logic   commit;
    } dp_cmd_t;

    typedef struct packed {
        logic wd_le0;
        logic wd_ge_dd;
        logic last;
    } dp_stat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic                      last_segment;
    } seg_t;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_ENDPT_A = 7'd35;
    localparam logic [PC_W-1:0] PC_ENDPT_B = 7'd41;
    localparam logic [PC_W-1:0] PC_THRESH  = 7'd47;

    function automatic uop_t op_mul(src_t a, src_t b, shift_t sh, logic neg, logic clr);
        uop_t u;
        u       = '0;
        u.kind  = OP_MUL;
        u.a     = a;
        u.b     = b;
        u.shift = sh;
        u.neg   = neg;
        u.clr   = clr;
        return u;
    endfunction

    function automatic uop_t op_st(dst_t d);
        uop_t u;
        u      = '0;
        u.kind = OP_STORE;
        u.dst  = d;
        return u;
    endfunction

    function automatic uop_t op_ctl(uop_kind_t k, logic [PC_W-1:0] t);
        uop_t u;
        u        = '0;
        u.kind   = k;
        u.target = t;
        return u;
    endfunction

    // Microprogram. A product passes through prod_reg and then into the accumulator,
    // so an idle NOP slot separates a store from its last multiply.
    function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // dd = |B - A|^2
            7'd0:  u = op_mul(SRC_D0, SRC_D0, SH_0, 1'b0, 1'b1);
            7'd1:  u = op_mul(SRC_D1, SRC_D1, SH_0, 1'b0, 1'b0);
            7'd2:  u = op_mul(SRC_D2, SRC_D2, SH_0, 1'b0, 1'b0);
            7'd3:  u = op_ctl(OP_NOP, '0);
            7'd4:  u = op_st(DST_DD);
            // wd = (C - A) . (B - A)
            7'd5:  u = op_mul(SRC_W0, SRC_D0, SH_0, 1'b0, 1'b1);
            7'd6:  u = op_mul(SRC_W1, SRC_D1, SH_0, 1'b0, 1'b0);
            7'd7:  u = op_mul(SRC_W2, SRC_D2, SH_0, 1'b0, 1'b0);
            7'd8:  u = op_ctl(OP_NOP, '0);
            7'd9:  u = op_st(DST_WD);
            7'd10: u = op_ctl(OP_BRANCH, PC_ENDPT_A);
            // interior: cross product w x d
            7'd11: u = op_mul(SRC_W1, SRC_D2, SH_0, 1'b0, 1'b1);
            7'd12: u = op_mul(SRC_W2, SRC_D1, SH_0, 1'b1, 1'b0);
            7'd13: u = op_ctl(OP_NOP, '0);
            7'd14: u = op_st(DST_CR0);
            7'd15: u = op_mul(SRC_W2, SRC_D0, SH_0, 1'b0, 1'b1);
            7'd16: u = op_mul(SRC_W0, SRC_D2, SH_0, 1'b1, 1'b0);
            7'd17: u = op_ctl(OP_NOP, '0);
            7'd18: u = op_st(DST_CR1);
            7'd19: u = op_mul(SRC_W0, SRC_D1, SH_0, 1'b0, 1'b1);
            7'd20: u = op_mul(SRC_W1, SRC_D0, SH_0, 1'b1, 1'b0);
            7'd21: u = op_ctl(OP_NOP, '0);
            7'd22: u = op_st(DST_CR2);
            // |cross|^2 from half-word pieces
            7'd23: u = op_mul(SRC_CH0, SRC_CH0, SH_PP, 1'b0, 1'b1);
            7'd24: u = op_mul(SRC_CH0, SRC_CL0, SH_P1, 1'b0, 1'b0);
            7'd25: u = op_mul(SRC_CL0, SRC_CL0, SH_0,  1'b0, 1'b0);
            7'd26: u = op_mul(SRC_CH1, SRC_CH1, SH_PP, 1'b0, 1'b0);
            7'd27: u = op_mul(SRC_CH1, SRC_CL1, SH_P1, 1'b0, 1'b0);
            7'd28: u = op_mul(SRC_CL1, SRC_CL1, SH_0,  1'b0, 1'b0);
            7'd29: u = op_mul(SRC_CH2, SRC_CH2, SH_PP, 1'b0, 1'b0);
            7'd30: u = op_mul(SRC_CH2, SRC_CL2, SH_P1, 1'b0, 1'b0);
            7'd31: u = op_mul(SRC_CL2, SRC_CL2, SH_0,  1'b0, 1'b0);
            7'd32: u = op_ctl(OP_NOP, '0);
            7'd33: u = op_st(DST_NUM_DD);
            7'd34: u = op_ctl(OP_JUMP, PC_THRESH);
            // nearest point is A
            7'd35: u = op_mul(SRC_W0, SRC_W0, SH_0, 1'b0, 1'b1);
            7'd36: u = op_mul(SRC_W1, SRC_W1, SH_0, 1'b0, 1'b0);
            7'd37: u = op_mul(SRC_W2, SRC_W2, SH_0, 1'b0, 1'b0);
            7'd38: u = op_ctl(OP_NOP, '0);
            7'd39: u = op_st(DST_NUM_ONE);
            7'd40: u = op_ctl(OP_JUMP, PC_THRESH);
            // nearest point is B
            7'd41: u = op_mul(SRC_V0, SRC_V0, SH_0, 1'b0, 1'b1);
            7'd42: u = op_mul(SRC_V1, SRC_V1, SH_0, 1'b0, 1'b0);
            7'd43: u = op_mul(SRC_V2, SRC_V2, SH_0, 1'b0, 1'b0);
            7'd44: u = op_ctl(OP_NOP, '0);
            7'd45: u = op_st(DST_NUM_ONE);
            7'd46: u = op_ctl(OP_JUMP, PC_THRESH);
            // inner threshold (R - M)^2 * den
            7'd47: u = op_mul(SRC_TIN, SRC_TIN, SH_0, 1'b0, 1'b1);
            7'd48: u = op_ctl(OP_NOP, '0);
            7'd49: u = op_st(DST_TSQ);
            7'd50: u = op_mul(SRC_DENH, SRC_TSQH, SH_PT, 1'b0, 1'b1);
            7'd51: u = op_mul(SRC_DENH, SRC_TSQL, SH_P,  1'b0, 1'b0);
            7'd52: u = op_mul(SRC_DENL, SRC_TSQH, SH_T,  1'b0, 1'b0);
            7'd53: u = op_mul(SRC_DENL, SRC_TSQL, SH_0,  1'b0, 1'b0);
            7'd54: u = op_ctl(OP_NOP, '0);
            7'd55: u = op_st(DST_CMP_IN);
            // outer threshold (R + M)^2 * den
            7'd56: u = op_mul(SRC_TOUT, SRC_TOUT, SH_0, 1'b0, 1'b1);
            7'd57: u = op_ctl(OP_NOP, '0);
            7'd58: u = op_st(DST_TSQ);
            7'd59: u = op_mul(SRC_DENH, SRC_TSQH, SH_PT, 1'b0, 1'b1);
            7'd60: u = op_mul(SRC_DENH, SRC_TSQL, SH_P,  1'b0, 1'b0);
            7'd61: u = op_mul(SRC_DENL, SRC_TSQH, SH_T,  1'b0, 1'b0);
            7'd62: u = op_mul(SRC_DENL, SRC_TSQL, SH_0,  1'b0, 1'b0);
            7'd63: u = op_ctl(OP_NOP, '0);
            7'd64: u = op_st(DST_CMP_TOUCH);
            default: u = op_ctl(OP_DONE, '0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/spc_if.sv
// Valid/ready channel interfaces for segments in and status out.
`default_nettype none

interface spc_seg_if;
    logic                               valid;
    logic                               ready;
    logic signed [spc_pkg::COORD_W-1:0] start_x;
    logic signed [spc_pkg::COORD_W-1:0] start_y;
    logic signed [spc_pkg::COORD_W-1:0] start_z;
    logic signed [spc_pkg::COORD_W-1:0] end_x;
    logic signed [spc_pkg::COORD_W-1:0] end_y;
    logic signed [spc_pkg::COORD_W-1:0] end_z;
    logic                               last_segment;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z, last_segment,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z, last_segment,
        output ready
    );
endinterface

interface spc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] contact_status;

    modport source (
        output valid, contact_status,
        input  ready
    );
    modport sink (
        input  valid, contact_status,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/spc_datapath.sv
// Datapath: config registers, shared multiplier, accumulator, compares, status.
`default_nettype none

module spc_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [spc_pkg::CFG_W-1:0]      cfg_data,
    input  wire spc_pkg::seg_t                  seg_data,
    input  wire spc_pkg::dp_cmd_t               cmd,
    output spc_pkg::dp_stat_t                   stat,
    output logic [1:0]                          contact_status
);

    localparam int COORD_W  = spc_pkg::COORD_W;
    localparam int DIFF_W   = spc_pkg::DIFF_W;
    localparam int MUL_W    = spc_pkg::MUL_W;
    localparam int PROD_W   = spc_pkg::PROD_W;
    localparam int PIECE_W  = spc_pkg::PIECE_W;
    localparam int MAG_W    = spc_pkg::MAG_W;
    localparam int DD_W     = spc_pkg::DD_W;
    localparam int NUM_W    = spc_pkg::NUM_W;
    localparam int ACC_W    = spc_pkg::ACC_W;
    localparam int RADIUS_W = spc_pkg::RADIUS_W;
    localparam int MARGIN_W = spc_pkg::MARGIN_W;
    localparam int T_W      = spc_pkg::T_W;
    localparam int TSQ_W    = spc_pkg::TSQ_W;

    // configuration
    logic signed [COORD_W-1:0] cen_x_reg, cen_y_reg, cen_z_reg;
    logic [RADIUS_W-1:0]       radius_reg;
    logic [MARGIN_W-1:0]       margin_reg;

    // per-segment operands
    logic signed [DIFF_W-1:0]  d_reg [3];
    logic signed [DIFF_W-1:0]  w_reg [3];
    logic signed [DIFF_W-1:0]  v_reg [3];
    logic                      last_reg;

    // multiplier stage and accumulator
    logic signed [PROD_W-1:0]  prod_reg;
    spc_pkg::shift_t           shift_reg;
    logic                      neg_reg, clr_reg, pvalid_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    // intermediate results
    logic [DD_W-1:0]           dd_reg;
    logic [DD_W-1:0]           den_reg;
    logic [MAG_W-1:0]          cmag_reg [3];
    logic [NUM_W-1:0]          num_reg;
    logic [TSQ_W-1:0]          tsq_reg;
    logic                      wd_le0_reg, wd_ge_dd_reg;
    logic                      hit_in_reg, hit_touch_reg;

    spc_pkg::status_t          status_reg, status_upd;
    spc_pkg::status_t          out_status_reg;

    logic signed [T_W-1:0]     t_in;
    logic [T_W-1:0]            t_out;
    logic signed [MUL_W-1:0]   op_a, op_b;
    logic signed [ACC_W-1:0]   prod_ext, prod_sh, acc_base;
    logic signed [ACC_W-1:0]   acc_abs, dd_ext, num_ext;
    logic                      inner_ok;

    assign t_in  = $signed({1'b0, radius_reg}) - $signed({{(T_W-MARGIN_W){1'b0}}, margin_reg});
    assign t_out = {1'b0, radius_reg} + {{(T_W-MARGIN_W){1'b0}}, margin_reg};
    assign inner_ok = radius_reg >= {{(RADIUS_W-MARGIN_W){1'b0}}, margin_reg};

    function automatic logic signed [MUL_W-1:0] sx_diff(logic signed [DIFF_W-1:0] x);
        return {{(MUL_W-DIFF_W){x[DIFF_W-1]}}, x};
    endfunction

    function automatic logic signed [MUL_W-1:0] zx_piece(logic [PIECE_W-1:0] x);
        return $signed({{(MUL_W-PIECE_W){1'b0}}, x});
    endfunction

    function automatic logic signed [MUL_W-1:0] zx_t(logic [T_W-1:0] x);
        return $signed({{(MUL_W-T_W){1'b0}}, x});
    endfunction

    function automatic logic signed [MUL_W-1:0] pick(spc_pkg::src_t s);
        case (s)
            spc_pkg::SRC_D0:   return sx_diff(d_reg[0]);
            spc_pkg::SRC_D1:   return sx_diff(d_reg[1]);
            spc_pkg::SRC_D2:   return sx_diff(d_reg[2]);
            spc_pkg::SRC_W0:   return sx_diff(w_reg[0]);
            spc_pkg::SRC_W1:   return sx_diff(w_reg[1]);
            spc_pkg::SRC_W2:   return sx_diff(w_reg[2]);
            spc_pkg::SRC_V0:   return sx_diff(v_reg[0]);
            spc_pkg::SRC_V1:   return sx_diff(v_reg[1]);
            spc_pkg::SRC_V2:   return sx_diff(v_reg[2]);
            spc_pkg::SRC_CH0:  return zx_piece(cmag_reg[0][MAG_W-1:PIECE_W]);
            spc_pkg::SRC_CH1:  return zx_piece(cmag_reg[1][MAG_W-1:PIECE_W]);
            spc_pkg::SRC_CH2:  return zx_piece(cmag_reg[2][MAG_W-1:PIECE_W]);
            spc_pkg::SRC_CL0:  return zx_piece(cmag_reg[0][PIECE_W-1:0]);
            spc_pkg::SRC_CL1:  return zx_piece(cmag_reg[1][PIECE_W-1:0]);
            spc_pkg::SRC_CL2:  return zx_piece(cmag_reg[2][PIECE_W-1:0]);
            spc_pkg::SRC_TIN:  return {{(MUL_W-T_W){t_in[T_W-1]}}, t_in};
            spc_pkg::SRC_TOUT: return zx_t(t_out);
            spc_pkg::SRC_DENH: return zx_piece(den_reg[DD_W-1:PIECE_W]);
            spc_pkg::SRC_DENL: return zx_piece(den_reg[PIECE_W-1:0]);
            spc_pkg::SRC_TSQH: return zx_t(tsq_reg[TSQ_W-1:T_W]);
            spc_pkg::SRC_TSQL: return zx_t(tsq_reg[T_W-1:0]);
            default:           return '0;
        endcase
    endfunction

    always_comb
    begin
        op_a = pick(cmd.a);
        op_b = pick(cmd.b);
    end

    // accumulate stage
    always_comb
    begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        case (shift_reg)
            spc_pkg::SH_0:  prod_sh = prod_ext;
            spc_pkg::SH_T:  prod_sh = prod_ext <<< T_W;
            spc_pkg::SH_P:  prod_sh = prod_ext <<< PIECE_W;
            spc_pkg::SH_P1: prod_sh = prod_ext <<< (PIECE_W + 1);
            spc_pkg::SH_PT: prod_sh = prod_ext <<< (PIECE_W + T_W);
            spc_pkg::SH_PP: prod_sh = prod_ext <<< (2 * PIECE_W);
            default:        prod_sh = prod_ext;
        endcase
        acc_base = clr_reg ? '0 : acc_reg;
        acc_next = acc_reg;
        if (pvalid_reg)
        begin
            acc_next = neg_reg ? (acc_base - prod_sh) : (acc_base + prod_sh);
        end
    end

    assign acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign dd_ext  = $signed({{(ACC_W-DD_W){1'b0}}, dd_reg});
    assign num_ext = $signed({{(ACC_W-NUM_W){1'b0}}, num_reg});

    // sticky status update for the current segment
    always_comb
    begin
        status_upd = status_reg;
        if (hit_in_reg)
        begin
            status_upd = spc_pkg::STAT_INTERSECT;
        end
        else if (hit_touch_reg && status_reg != spc_pkg::STAT_INTERSECT)
        begin
            status_upd = spc_pkg::STAT_TOUCH;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_x_reg  <= '0;
            cen_y_reg  <= '0;
            cen_z_reg  <= '0;
            radius_reg <= spc_pkg::RADIUS_RESET;
            margin_reg <= spc_pkg::MARGIN_RESET;
            pvalid_reg <= 1'b0;
            status_reg <= spc_pkg::STAT_AWAY;
        end
        else
        begin
            if (cfg_we)
            begin
                case (spc_pkg::cfg_idx_t'(cfg_index))
                    spc_pkg::CFG_CENTER_X: cen_x_reg  <= $signed(cfg_data[COORD_W-1:0]);
                    spc_pkg::CFG_CENTER_Y: cen_y_reg  <= $signed(cfg_data[COORD_W-1:0]);
                    spc_pkg::CFG_CENTER_Z: cen_z_reg  <= $signed(cfg_data[COORD_W-1:0]);
                    spc_pkg::CFG_RADIUS:   radius_reg <= cfg_data[RADIUS_W-1:0];
                    spc_pkg::CFG_MARGIN:   margin_reg <= cfg_data[MARGIN_W-1:0];
                    default:               ;
                endcase
            end
            pvalid_reg <= cmd.mul_en;
            if (cmd.commit)
            begin
                status_reg <= last_reg ? spc_pkg::STAT_AWAY : status_upd;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg[0] <= DIFF_W'(seg_data.end_x) - DIFF_W'(seg_data.start_x);
            d_reg[1] <= DIFF_W'(seg_data.end_y) - DIFF_W'(seg_data.start_y);
            d_reg[2] <= DIFF_W'(seg_data.end_z) - DIFF_W'(seg_data.start_z);
            w_reg[0] <= DIFF_W'(cen_x_reg) - DIFF_W'(seg_data.start_x);
            w_reg[1] <= DIFF_W'(cen_y_reg) - DIFF_W'(seg_data.start_y);
            w_reg[2] <= DIFF_W'(cen_z_reg) - DIFF_W'(seg_data.start_z);
            v_reg[0] <= DIFF_W'(cen_x_reg) - DIFF_W'(seg_data.end_x);
            v_reg[1] <= DIFF_W'(cen_y_reg) - DIFF_W'(seg_data.end_y);
            v_reg[2] <= DIFF_W'(cen_z_reg) - DIFF_W'(seg_data.end_z);
            last_reg <= seg_data.last_segment;
        end

        if (cmd.mul_en)
        begin
            prod_reg  <= op_a * op_b;
            shift_reg <= cmd.shift;
            neg_reg   <= cmd.neg;
            clr_reg   <= cmd.clr;
        end
        acc_reg <= acc_next;

        if (cmd.st_en)
        begin
            case (cmd.dst)
                spc_pkg::DST_DD:  dd_reg <= acc_reg[DD_W-1:0];
                spc_pkg::DST_WD:
                begin
                    wd_le0_reg   <= acc_reg[ACC_W-1] || (acc_reg == '0);
                    wd_ge_dd_reg <= acc_reg >= dd_ext;
                end
                spc_pkg::DST_CR0: cmag_reg[0] <= acc_abs[MAG_W-1:0];
                spc_pkg::DST_CR1: cmag_reg[1] <= acc_abs[MAG_W-1:0];
                spc_pkg::DST_CR2: cmag_reg[2] <= acc_abs[MAG_W-1:0];
                spc_pkg::DST_NUM_DD:
                begin
                    num_reg <= acc_reg[NUM_W-1:0];
                    den_reg <= dd_reg;
                end
                spc_pkg::DST_NUM_ONE:
                begin
                    num_reg <= acc_reg[NUM_W-1:0];
                    den_reg <= DD_W'(1);
                end
                spc_pkg::DST_TSQ:       tsq_reg       <= acc_reg[TSQ_W-1:0];
                spc_pkg::DST_CMP_IN:    hit_in_reg    <= inner_ok && (num_ext <= acc_reg);
                spc_pkg::DST_CMP_TOUCH: hit_touch_reg <= num_ext < acc_reg;
                default:                ;
            endcase
        end

        if (cmd.commit && last_reg)
        begin
            out_status_reg <= status_upd;
        end
    end

    assign stat.wd_le0   = wd_le0_reg;
    assign stat.wd_ge_dd = wd_ge_dd_reg;
    assign stat.last     = last_reg;
    assign contact_status = out_status_reg;

endmodule

`default_nettype wire

>>> hw/rtl/spc_ctrl.sv
// Controller: request handshake, microprogram sequencer, result valid.
`default_nettype none

module spc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output spc_pkg::dp_cmd_t         cmd,
    input  wire spc_pkg::dp_stat_t   stat
);

    localparam int PC_W = spc_pkg::PC_W;

    spc_pkg::ctl_state_t state_reg, state_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic                out_valid_reg, out_valid_next;
    spc_pkg::uop_t       uop;
    logic                commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spc_pkg::CTL_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        uop        = spc_pkg::uop_rom(pc_reg);
        in_ready   = 1'b0;
        commit     = 1'b0;
        cmd        = '0;
        cmd.a      = uop.a;
        cmd.b      = uop.b;
        cmd.shift  = uop.shift;
        cmd.neg    = uop.neg;
        cmd.clr    = uop.clr;
        cmd.dst    = uop.dst;

        case (state_reg)
            spc_pkg::CTL_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pc_next    = '0;
                    state_next = spc_pkg::CTL_RUN;
                end
            end
            spc_pkg::CTL_RUN:
            begin
                pc_next = pc_reg + PC_W'(1);
                case (uop.kind)
                    spc_pkg::OP_MUL:   cmd.mul_en = 1'b1;
                    spc_pkg::OP_STORE: cmd.st_en  = 1'b1;
                    spc_pkg::OP_BRANCH:
                    begin
                        // nearest point is A, is B, or lies inside
                        if (stat.wd_le0)
                        begin
                            pc_next = uop.target;
                        end
                        else if (stat.wd_ge_dd)
                        begin
                            pc_next = spc_pkg::PC_ENDPT_B;
                        end
                    end
                    spc_pkg::OP_JUMP:  pc_next = uop.target;
                    spc_pkg::OP_DONE:  state_next = spc_pkg::CTL_COMMIT;
                    default:           ;
                endcase
            end
            spc_pkg::CTL_COMMIT:
            begin
                // a last segment waits for the output register to free up
                if (!stat.last || !out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    state_next = spc_pkg::CTL_IDLE;
                end
            end
            default: state_next = spc_pkg::CTL_IDLE;
        endcase

        cmd.commit     = commit;
        out_valid_next = (out_valid_reg && !out_ready) || (commit && stat.last);
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sphere_polyline_contact_classifier.sv
// Top level of the sphere / polyline contact classifier.
`default_nettype none
`include "sphere_polyline_contact_classifier_macros.svh"

// Usage:
//  - Set up center_x/y/z, sphere_radius and touch_margin through the write
//    port (cfg_we, cfg_index, cfg_data) while no segment is in flight.
//  - Segments enter on seg, one request per segment: two Q15.8 endpoints and
//    last_segment. Each segment updates a sticky class (intersect, touch,
//    away) from its exact squared distance to the center.
//  - A segment with last_segment set produces one request on res carrying
//    contact_status; the class then returns to away. Others produce nothing.
//  - Timing: one shared 26x26 multiplier runs a microprogram, at most one product per
//    cycle. A segment whose nearest point is interior runs a longer program than
//    one whose nearest point is an endpoint (cross product plus squaring its
//    halves). One segment is in work at a time.
//  - The result sits in an output register; seg is accepted again while it
//    waits. If res stalls, the next last segment holds in its commit step
//    until the register drains.
//  - Reset (rst_n, async low) restores the register defaults (radius 5.0,
//    margin 102/256), clears the sticky class to away and drops res.valid.
module sphere_polyline_contact_classifier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spc_pkg::CFG_W-1:0]     cfg_data,
    spc_seg_if.sink                            seg,
    spc_res_if.source                          res
);

    spc_pkg::dp_cmd_t  cmd;
    spc_pkg::dp_stat_t stat;
    spc_pkg::seg_t     seg_data;
    logic              in_ready;
    logic              out_valid;
    logic [1:0]        status_out;

    assign seg_data.start_x      = seg.start_x;
    assign seg_data.start_y      = seg.start_y;
    assign seg_data.start_z      = seg.start_z;
    assign seg_data.end_x        = seg.end_x;
    assign seg_data.end_y        = seg.end_y;
    assign seg_data.end_z        = seg.end_z;
    assign seg_data.last_segment = seg.last_segment;

    // sequencer
    spc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // arithmetic and state
    spc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .seg_data       (seg_data),
        .cmd            (cmd),
        .stat           (stat),
        .contact_status (status_out)
    );

    assign seg.ready          = in_ready;
    assign res.valid          = out_valid;
    assign res.contact_status = status_out;

    // busy right after taking a segment
    `SPC_ASSERT_NEXT(a_busy_after_request, seg.valid && seg.ready, !seg.ready)
    // commits only happen while a segment is in work
    `SPC_ASSERT_IMP(a_commit_while_busy, cmd.commit, !seg.ready)
    // a result only appears right after a commit
    `SPC_ASSERT_IMP(a_result_from_commit, $rose(res.valid), $past(cmd.commit))

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the sphere / polyline contact classifier.
`timescale 1ns / 100ps

module tb_top;

    localparam int COORD_W   = spc_pkg::COORD_W;
    localparam int CFG_W     = spc_pkg::CFG_W;
    localparam int CFG_IDX_W = spc_pkg::CFG_IDX_W;
    localparam int RADIUS_W  = spc_pkg::RADIUS_W;
    localparam int MARGIN_W  = spc_pkg::MARGIN_W;

    // Wide enough for den * (R + M)^2 and for the squared cross product.
    typedef logic signed [159:0] big_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int SETTLE_CYCLES = 80;   // longer than one segment in work
    localparam int PHASE_ITEMS   = 100;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    spc_seg_if seg ();
    spc_res_if res ();

    sphere_polyline_contact_classifier i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seg       (seg.sink),
        .res       (res.source)
    );

    // Shadow copy of the sphere set-up and the sticky class.
    logic signed [COORD_W-1:0] sph_cx, sph_cy, sph_cz;
    logic [RADIUS_W-1:0] sph_radius;
    logic [MARGIN_W-1:0] sph_margin;
    spc_pkg::status_t sticky_status;

    spc_pkg::seg_t    seg_pending[$];
    spc_pkg::status_t status_expected[$];
    int               error_count;

    // Sender burst/gap state and receiver stall state.
    logic seg_taken;
    int   burst_left;
    int   gap_left;
    int   stall_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Classify one segment against the shadow sphere and update the sticky
    // class; returns 1 when a status comes out for this segment.
    function automatic bit classify_segment(input spc_pkg::seg_t s,
                                            output spc_pkg::status_t emitted);
        big_t ax, ay, az, bx, by, bz, cx, cy, cz;
        big_t dx, dy, dz, wx, wy, wz, dd, wd, num, den;
        big_t c0, c1, c2, rr, mm, tin, tout;
        bit   inner_hit, touch_hit;
        ax = s.start_x; ay = s.start_y; az = s.start_z;
        bx = s.end_x;   by = s.end_y;   bz = s.end_z;
        cx = sph_cx;    cy = sph_cy;    cz = sph_cz;
        dx = bx - ax;   dy = by - ay;   dz = bz - az;
        wx = cx - ax;   wy = cy - ay;   wz = cz - az;
        dd = dx * dx + dy * dy + dz * dz;
        wd = wx * dx + wy * dy + wz * dz;
        if (wd <= 0)
        begin
            // nearest point is the first endpoint (also zero-length segments)
            num = wx * wx + wy * wy + wz * wz;
            den = 1;
        end
        else if (wd >= dd)
        begin
            num = (cx - bx) * (cx - bx) + (cy - by) * (cy - by) + (cz - bz) * (cz - bz);
            den = 1;
        end
        else
        begin
            // interior: |w x d|^2 / |d|^2, kept as a fraction
            c0 = wy * dz - wz * dy;
            c1 = wz * dx - wx * dz;
            c2 = wx * dy - wy * dx;
            num = c0 * c0 + c1 * c1 + c2 * c2;
            den = dd;
        end
        rr = big_t'(sph_radius);
        mm = big_t'(sph_margin);
        tin  = rr - mm;
        tout = rr + mm;
        // margin above radius: nothing can intersect
        inner_hit = (rr >= mm) && (num <= den * tin * tin);
        touch_hit = num < den * tout * tout;
        if (inner_hit)
            sticky_status = spc_pkg::STAT_INTERSECT;
        else if (touch_hit && sticky_status != spc_pkg::STAT_INTERSECT)
            sticky_status = spc_pkg::STAT_TOUCH;
        emitted = sticky_status;
        if (s.last_segment)
        begin
            sticky_status = spc_pkg::STAT_AWAY;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Accepted segment -> expected status, if any.
    always @(posedge clk)
    begin
        spc_pkg::seg_t    s;
        spc_pkg::status_t st;
        if (rst_n && seg.valid && seg.ready)
        begin
            s.start_x = seg.start_x; s.start_y = seg.start_y; s.start_z = seg.start_z;
            s.end_x   = seg.end_x;   s.end_y   = seg.end_y;   s.end_z   = seg.end_z;
            s.last_segment = seg.last_segment;
            if (classify_segment(s, st))
                status_expected = {status_expected, st};
            seg_taken <= 1'b1;
        end
        else
            seg_taken <= 1'b0;
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (status_expected.size() == 0)
            begin
                $error("contact_status: unexpected request, value %0d", res.contact_status);
                error_count++;
            end
            else
            begin
                if (res.contact_status !== status_expected[0])
                begin
                    $error("contact_status: expected %0d, actual %0d",
                           status_expected[0], res.contact_status);
                    error_count++;
                end
                void'(status_expected.pop_front());
            end
        end
    end

    // Segment driver: bursts of requests with random gaps.
    always @(negedge clk)
    begin
        spc_pkg::seg_t s;
        if (rst_n)
        begin
            if (seg.valid && !seg_taken)
            begin
                // request still waiting, hold it
            end
            else if (gap_left > 0)
            begin
                seg.valid <= 1'b0;
                gap_left  <= gap_left - 1;
            end
            else if (seg_pending.size() > 0)
            begin
                s = seg_pending.pop_front();
                seg.start_x <= s.start_x; seg.start_y <= s.start_y;
                seg.start_z <= s.start_z;
                seg.end_x   <= s.end_x;   seg.end_y   <= s.end_y;
                seg.end_z   <= s.end_z;
                seg.last_segment <= s.last_segment;
                seg.valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                seg.valid <= 1'b0;
        end
    end

    // Receiver: ready runs and stall runs of random length.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
                stall_left <= stall_left - 1;
            else
            begin
                res.ready  <= ~res.ready;
                stall_left <= res.ready ? $urandom_range(0, 120) : $urandom_range(0, 300);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            spc_pkg::CFG_CENTER_X: sph_cx = val;
            spc_pkg::CFG_CENTER_Y: sph_cy = val;
            spc_pkg::CFG_CENTER_Z: sph_cz = val;
            spc_pkg::CFG_RADIUS:   sph_radius = val[RADIUS_W-1:0];
            spc_pkg::CFG_MARGIN:   sph_margin = val[MARGIN_W-1:0];
            default: ;  // out-of-range index is dropped
        endcase
    endtask

    task automatic set_sphere(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                              input logic [CFG_W-1:0] z, input logic [RADIUS_W-1:0] r,
                              input logic [MARGIN_W-1:0] m);
        write_reg(spc_pkg::CFG_CENTER_X, x);
        write_reg(spc_pkg::CFG_CENTER_Y, y);
        write_reg(spc_pkg::CFG_CENTER_Z, z);
        write_reg(spc_pkg::CFG_RADIUS, CFG_W'(r));
        write_reg(spc_pkg::CFG_MARGIN, CFG_W'(m));
    endtask

    function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] c, input int span);
        return c + COORD_W'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic spc_pkg::seg_t make_seg(input logic signed [COORD_W-1:0] ax,
                                               input logic signed [COORD_W-1:0] ay,
                                               input logic signed [COORD_W-1:0] az,
                                               input logic signed [COORD_W-1:0] bx,
                                               input logic signed [COORD_W-1:0] by,
                                               input logic signed [COORD_W-1:0] bz,
                                               input logic last);
        spc_pkg::seg_t s;
        s.start_x = ax; s.start_y = ay; s.start_z = az;
        s.end_x   = bx; s.end_y   = by; s.end_z   = bz;
        s.last_segment = last;
        return s;
    endfunction

    // Random segment, mostly placed around the current sphere.
    function automatic spc_pkg::seg_t random_seg();
        spc_pkg::seg_t s;
        int   span;
        int   pick;
        span = int'(sph_radius) + int'(sph_margin) + 16;
        if (span > 4_000_000)
            span = 4_000_000;
        pick = $urandom_range(0, 9);
        s.last_segment = ($urandom_range(0, 3) == 0);
        if (pick < 5)
        begin
            s.start_x = near_coord(sph_cx, 2 * span); s.start_y = near_coord(sph_cy, 2 * span);
            s.start_z = near_coord(sph_cz, 2 * span); s.end_x = near_coord(sph_cx, 2 * span);
            s.end_y   = near_coord(sph_cy, 2 * span); s.end_z = near_coord(sph_cz, 2 * span);
        end
        else if (pick < 7)
        begin
            // long segment passing close to the center
            s.start_x = near_coord(sph_cx, span / 2); s.start_y = near_coord(sph_cy, span / 2);
            s.start_z = near_coord(sph_cz, span / 2);
            s.end_x = COORD_W'(2 * sph_cx - s.start_x
                               + COORD_W'($urandom_range(0, 2 * span) - span));
            s.end_y = COORD_W'(2 * sph_cy - s.start_y
                               + COORD_W'($urandom_range(0, 2 * span) - span));
            s.end_z = COORD_W'(2 * sph_cz - s.start_z);
        end
        else if (pick < 8)
        begin
            // zero-length segment
            s.start_x = near_coord(sph_cx, span); s.start_y = near_coord(sph_cy, span);
            s.start_z = near_coord(sph_cz, span);
            s.end_x = s.start_x; s.end_y = s.start_y; s.end_z = s.start_z;
        end
        else
        begin
            s.start_x = COORD_W'($urandom); s.start_y = COORD_W'($urandom);
            s.start_z = COORD_W'($urandom);
            s.end_x   = COORD_W'($urandom); s.end_y   = COORD_W'($urandom);
            s.end_z   = COORD_W'($urandom);
        end
        return s;
    endfunction

    task automatic drain();
        wait (seg_pending.size() == 0 && !seg.valid);
        wait (status_expected.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        repeat (count) seg_pending = {seg_pending, random_seg()};
        // close the set so the phase ends with nothing sticky
        seg_pending = {seg_pending,
                       make_seg(sph_cx, sph_cy, sph_cz, sph_cx, sph_cy, sph_cz, 1'b1)};
        drain();
    endtask

    localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C0   = '0;

    initial
    begin
        error_count = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        seg.valid  = 1'b0;
        seg.start_x = '0; seg.start_y = '0; seg.start_z = '0;
        seg.end_x   = '0; seg.end_y   = '0; seg.end_z   = '0;
        seg.last_segment = 1'b0;
        res.ready  = 1'b1;
        seg_taken  = 1'b0;
        burst_left = 4;
        gap_left   = 0;
        stall_left = 20;
        sph_cx = '0; sph_cy = '0; sph_cz = '0;
        sph_radius = spc_pkg::RADIUS_RESET;
        sph_margin = spc_pkg::MARGIN_RESET;
        sticky_status = spc_pkg::STAT_AWAY;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset set-up: R - M = 1178, R + M = 1382.
        seg_pending = {seg_pending, make_seg(C0, C0, C0, C0, C0, C0, 1'b1)}; // point at center
        seg_pending = {seg_pending,                                          // on inner bound
                       make_seg(24'sd1178, C0, C0, 24'sd1178, C0, C0, 1'b1)};
        seg_pending = {seg_pending,                                          // just outside it
                       make_seg(C0, 24'sd1179, C0, C0, 24'sd1179, C0, 1'b1)};
        seg_pending = {seg_pending,                                          // inside touch band
                       make_seg(C0, C0, 24'sd1381, C0, C0, 24'sd1381, 1'b1)};
        seg_pending = {seg_pending,                                          // on outer bound
                       make_seg(C0, C0, -24'sd1382, C0, C0, -24'sd1382, 1'b1)};
        seg_pending = {seg_pending,                                          // interior, intersect
                       make_seg(-24'sd5000, 24'sd1000, C0, 24'sd5000, 24'sd1000, C0, 1'b1)};
        seg_pending = {seg_pending,                                          // interior, through
                       make_seg(-24'sd5000, C0, C0, 24'sd5000, C0, C0, 1'b0)};
        seg_pending = {seg_pending,                                          // sticky kept
                       make_seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b1)};
        seg_pending = {seg_pending,                                          // full diagonal
                       make_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0)};
        seg_pending = {seg_pending, make_seg(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 1'b1)};
        seg_pending = {seg_pending,                                          // nearest is start
                       make_seg(24'sd2000, C0, C0, 24'sd3000, C0, C0, 1'b0)};
        seg_pending = {seg_pending,                                          // nearest is end
                       make_seg(24'sd3000, C0, C0, 24'sd1300, C0, C0, 1'b1)};
        seg_pending = {seg_pending, make_seg(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1)};
        drain();

        // Ignored register index must not disturb anything.
        write_reg(CFG_UNUSED_IDX, {CFG_W{1'b1}});
        random_phase(PHASE_ITEMS);

        // Random placement and size.
        set_sphere(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                   RADIUS_W'($urandom_range(0, 60000)), MARGIN_W'($urandom_range(0, 4000)));
        random_phase(PHASE_ITEMS);

        // Margin equal to radius: only a segment through the center intersects.
        set_sphere(24'd1000, -24'sd2000, 24'd300, 20'd3000, 16'd3000);
        seg_pending = {seg_pending, make_seg(-24'sd100, -24'sd2000, 24'sd300,
                                             24'sd2100, -24'sd2000, 24'sd300, 1'b1)};
        random_phase(PHASE_ITEMS / 2);

        // Margin above radius: touch only.
        set_sphere(CMIN, CMAX, CMIN, 20'd500, 16'hFFFF);
        random_phase(PHASE_ITEMS);

        // Extremes: largest radius and margin at the far corner.
        set_sphere(CMAX, CMAX, CMAX, {RADIUS_W{1'b1}}, {MARGIN_W{1'b1}});
        random_phase(PHASE_ITEMS);

        // Zero radius and margin: only an exact hit intersects.
        set_sphere(CMIN, CMIN, CMIN, '0, '0);
        seg_pending = {seg_pending, make_seg(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1)};
        random_phase(PHASE_ITEMS);

        set_sphere(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                   RADIUS_W'($urandom), MARGIN_W'($urandom));
        random_phase(PHASE_ITEMS + PHASE_ITEMS / 2);

        if (status_expected.size() != 0)
        begin
            $error("contact_status: %0d expected requests never came", status_expected.size());
            error_count++;
        end
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
